// ----- src/array_list_engine_unit_macros.svh -----
// Assertion macros for the array list engine.
// Used by the top level; depends on nothing else.
`ifndef ARRAY_LIST_ENGINE_UNIT_MACROS_SVH
`define ARRAY_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ALE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ALE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/alist_pkg.sv -----
// Shared types, command and status codes for the array list engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package alist_pkg;

    // Store geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Fixed field widths
    localparam int CMD_W  = 4;
    localparam int POS_W  = 4;
    localparam int FPOS_W = 4;
    localparam int ECNT_W = 5;
    localparam int ST_W   = 2;

    localparam int IN_W   = 40;
    localparam int OUT_W  = 48;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_GET     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SET     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_POP     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FIND    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 4'd8;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    // One input item
    typedef struct packed {
        logic [DATA_W-1:0] handle;
        logic [POS_W-1:0]  position;
        logic [CMD_W-1:0]  command;
    } item_t;

    // One result item
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              is_empty;
        logic [ECNT_W-1:0] entry_count;
        logic              found;
        logic [FPOS_W-1:0] found_position;
        logic [DATA_W-1:0] handle_out;
    } result_t;

    // Store access from the sequencer
    typedef struct packed {
        logic              we;
        logic              inv;
        logic              clr_all;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

endpackage

`default_nettype wire

// ----- src/alist_ram.sv -----
// Slot store: one write port, one registered read port, per-slot valid bits.
// Depends on alist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alist_ram (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire alist_pkg::ram_req_t       req,
    output logic [alist_pkg::DATA_W-1:0]   rdata
);
    import alist_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] mem_q_reg;
    logic              vld_q_reg;

    // Data array write and registered read
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        mem_q_reg <= mem[req.raddr];
        vld_q_reg <= valid_reg[req.raddr];
    end

    // Valid bits: unwritten or cleared slots read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.clr_all) begin
            valid_reg <= '0;
        end else if (req.we) begin
            valid_reg[req.waddr] <= 1'b1;
        end else if (req.inv) begin
            valid_reg[req.waddr] <= 1'b0;
        end
    end

    assign rdata = vld_q_reg ? mem_q_reg : '0;

endmodule

`default_nettype wire

// ----- src/alist_ctrl.sv -----
// Command sequencer: walks the slot store one access at a time with index
// adders and compares shared across states. Depends on alist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alist_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    input  wire alist_pkg::item_t         in_item,
    output logic                          in_ready,
    output alist_pkg::ram_req_t           ram_req,
    input  wire logic [alist_pkg::DATA_W-1:0] ram_rdata,
    output logic                          res_valid,
    output alist_pkg::result_t            res,
    input  wire logic                     res_ready
);
    import alist_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_RDW     = 4'd2;
    localparam logic [3:0] S_INS_CHK = 4'd3;
    localparam logic [3:0] S_INS_MV  = 4'd4;
    localparam logic [3:0] S_REM_CHK = 4'd5;
    localparam logic [3:0] S_REM_MV  = 4'd6;
    localparam logic [3:0] S_FND_CHK = 4'd7;
    localparam logic [3:0] S_FND_CMP = 4'd8;
    localparam logic [3:0] S_REV_CHK = 4'd9;
    localparam logic [3:0] S_REV_A   = 4'd10;
    localparam logic [3:0] S_REV_B   = 4'd11;
    localparam logic [3:0] S_REV_C   = 4'd12;
    localparam logic [3:0] S_RESP    = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] tmp_reg, tmp_next;
    logic [DATA_W-1:0] hout_reg, hout_next;
    logic [IDX_W-1:0]  fpos_reg, fpos_next;
    logic              fnd_reg, fnd_next;
    logic [ST_W-1:0]   st_reg, st_next;

    // Shared index arithmetic
    logic [CNT_W-1:0] idx_inc, idx_dec, cnt_inc, cnt_dec, hi_dec, pos_ext;
    logic             is_full, is_zero;

    assign idx_inc = idx_reg + 1'b1;
    assign idx_dec = idx_reg - 1'b1;
    assign cnt_inc = count_reg + 1'b1;
    assign cnt_dec = count_reg - 1'b1;
    assign hi_dec  = hi_reg - 1'b1;
    assign pos_ext = CNT_W'(pos_reg);
    assign is_full = (count_reg >= CNT_W'(DEPTH));
    assign is_zero = (count_reg == '0);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working and result registers
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        hi_reg   <= hi_next;
        cmd_reg  <= cmd_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        tmp_reg  <= tmp_next;
        hout_reg <= hout_next;
        fpos_reg <= fpos_next;
        fnd_reg  <= fnd_next;
        st_reg   <= st_next;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        hi_next    = hi_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        tmp_next   = tmp_reg;
        hout_next  = hout_reg;
        fpos_next  = fpos_reg;
        fnd_next   = fnd_reg;
        st_next    = st_reg;
        ram_req    = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next   = in_item.command;
                    pos_next   = in_item.position;
                    val_next   = in_item.handle;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                hout_next  = '0;
                fpos_next  = '0;
                fnd_next   = 1'b0;
                st_next    = ST_OK;
                state_next = S_RESP;
                case (cmd_reg)
                    CMD_ADD: begin
                        if (is_full) begin
                            st_next = ST_FULL;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = count_reg[IDX_W-1:0];
                            ram_req.wdata = val_reg;
                            count_next    = cnt_inc;
                        end
                    end
                    CMD_GET: begin
                        if (pos_ext >= count_reg) begin
                            st_next = ST_RANGE;
                        end else begin
                            ram_req.raddr = IDX_W'(pos_reg);
                            state_next    = S_RDW;
                        end
                    end
                    CMD_SET: begin
                        if (pos_ext >= count_reg) begin
                            st_next = ST_RANGE;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = IDX_W'(pos_reg);
                            ram_req.wdata = val_reg;
                        end
                    end
                    CMD_INSERT: begin
                        if (is_full) begin
                            st_next = ST_FULL;
                        end else if (pos_ext > count_reg) begin
                            st_next = ST_RANGE;
                        end else begin
                            idx_next   = count_reg;
                            state_next = S_INS_CHK;
                        end
                    end
                    CMD_REMOVE: begin
                        if (is_zero) begin
                            st_next = ST_EMPTY;
                        end else if (pos_ext >= count_reg) begin
                            st_next = ST_RANGE;
                        end else begin
                            ram_req.raddr = IDX_W'(pos_reg);
                            idx_next      = pos_ext;
                            state_next    = S_RDW;
                        end
                    end
                    CMD_POP: begin
                        if (is_zero) begin
                            st_next = ST_EMPTY;
                        end else begin
                            ram_req.raddr = cnt_dec[IDX_W-1:0];
                            state_next    = S_RDW;
                        end
                    end
                    CMD_FIND: begin
                        idx_next   = '0;
                        state_next = S_FND_CHK;
                    end
                    CMD_CLEAR: begin
                        ram_req.clr_all = 1'b1;
                        count_next      = '0;
                    end
                    CMD_REVERSE: begin
                        idx_next   = '0;
                        hi_next    = count_reg;
                        state_next = S_REV_CHK;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            // Read data back for get, remove and pop
            S_RDW: begin
                hout_next = ram_rdata;
                if (cmd_reg == CMD_POP) begin
                    ram_req.inv   = 1'b1;
                    ram_req.waddr = cnt_dec[IDX_W-1:0];
                    count_next    = cnt_dec;
                    state_next    = S_RESP;
                end else if (cmd_reg == CMD_REMOVE) begin
                    state_next = S_REM_CHK;
                end else begin
                    state_next = S_RESP;
                end
            end
            // Insert: shift entries up from the top, then place the new one
            S_INS_CHK: begin
                if (idx_reg > pos_ext) begin
                    ram_req.raddr = idx_dec[IDX_W-1:0];
                    state_next    = S_INS_MV;
                end else begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = IDX_W'(pos_reg);
                    ram_req.wdata = val_reg;
                    count_next    = cnt_inc;
                    state_next    = S_RESP;
                end
            end
            S_INS_MV: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg[IDX_W-1:0];
                ram_req.wdata = ram_rdata;
                idx_next      = idx_dec;
                state_next    = S_INS_CHK;
            end
            // Remove: shift later entries down, then drop the top slot
            S_REM_CHK: begin
                if (idx_inc < count_reg) begin
                    ram_req.raddr = idx_inc[IDX_W-1:0];
                    state_next    = S_REM_MV;
                end else begin
                    ram_req.inv   = 1'b1;
                    ram_req.waddr = idx_reg[IDX_W-1:0];
                    count_next    = cnt_dec;
                    state_next    = S_RESP;
                end
            end
            S_REM_MV: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg[IDX_W-1:0];
                ram_req.wdata = ram_rdata;
                idx_next      = idx_inc;
                state_next    = S_REM_CHK;
            end
            // Find: linear scan from slot zero
            S_FND_CHK: begin
                if (idx_reg < count_reg) begin
                    ram_req.raddr = idx_reg[IDX_W-1:0];
                    state_next    = S_FND_CMP;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_FND_CMP: begin
                if (ram_rdata == val_reg) begin
                    fnd_next   = 1'b1;
                    fpos_next  = idx_reg[IDX_W-1:0];
                    state_next = S_RESP;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_FND_CHK;
                end
            end
            // Reverse: swap the low and high ends, moving inward
            S_REV_CHK: begin
                if (idx_inc < hi_reg) begin
                    ram_req.raddr = idx_reg[IDX_W-1:0];
                    hi_next       = hi_dec;
                    state_next    = S_REV_A;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_REV_A: begin
                tmp_next      = ram_rdata;
                ram_req.raddr = hi_reg[IDX_W-1:0];
                state_next    = S_REV_B;
            end
            S_REV_B: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg[IDX_W-1:0];
                ram_req.wdata = ram_rdata;
                state_next    = S_REV_C;
            end
            S_REV_C: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = hi_reg[IDX_W-1:0];
                ram_req.wdata = tmp_reg;
                idx_next      = idx_inc;
                state_next    = S_REV_CHK;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);

    // Result fields
    always_comb begin
        res.handle_out     = hout_reg;
        res.found_position = FPOS_W'(fpos_reg);
        res.found          = fnd_reg;
        res.entry_count    = ECNT_W'(count_reg);
        res.is_empty       = is_zero;
        res.status         = st_reg;
    end

endmodule

`default_nettype wire

// ----- src/array_list_engine_unit.sv -----
// Top level of the array list engine: stream ports, output register,
// sequencer and slot store. Depends on alist_pkg, alist_ctrl, alist_ram.
//
//  channel  dir  payload                                     bytes
//  s_       in   command, position, handle                   5
//  m_       out  handle_out, found_position, found,          6
//                entry_count, is_empty, status
//
// One item at a time; a slot access is a read followed by a write on the
// store's single read and write ports. Insert and remove shift the entries
// between the position and the top one slot at a time, find compares slots
// in order from slot zero until a match, and reverse swaps pairs of slots
// from both ends toward the middle.
// Reset (aresetn low, synchronous) empties the list: the valid bits of the
// store drop at once and there is no clearing pass.
// A finished result sits in the output register; the next item is taken
// while it waits, and the sequencer holds its own result only if that
// register is full and m_tready is low.
`timescale 1ns / 1ps
`default_nettype none

`include "array_list_engine_unit_macros.svh"

module array_list_engine_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [3:0] command, [7:4] position, [39:8] handle
    input  wire logic [alist_pkg::IN_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [31:0] handle_out, [35:32] found_position, [36] found,
    // [41:37] entry_count, [42] is_empty, [44:43] status, [47:45] zero
    output logic [alist_pkg::OUT_W-1:0]      m_tdata
);
    import alist_pkg::*;

    item_t             item;
    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg;

    assign item = item_t'(s_tdata);

    alist_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_item   (item),
        .in_ready  (s_tready),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    alist_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rdata   (ram_rdata)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    // Checks
    `ALE_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted a second item while busy")
    `ALE_ASSERT_IMP(a_count_bound, aclk, aresetn, m_tvalid, out_data_reg.entry_count <= ECNT_W'(DEPTH), "entry count above capacity")
    `ALE_ASSERT_IMP(a_empty_flag, aclk, aresetn, m_tvalid, out_data_reg.is_empty == (out_data_reg.entry_count == '0), "empty flag disagrees with count")
    `ALE_ASSERT_IMP(a_found_ok, aclk, aresetn, m_tvalid && out_data_reg.found, out_data_reg.status == ST_OK, "found with an error status")

endmodule

`default_nettype wire
